// ----- hw/rtl/integer_mul_div_sqrt_unit_macros.svh -----
// assertion macros for the integer multiply, divide and square-root unit
`ifndef INTEGER_MUL_DIV_SQRT_UNIT_MACROS_SVH
`define INTEGER_MUL_DIV_SQRT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge out of reset
`define IMDS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imds assertion failed");

// condition must never be seen out of reset
`define IMDS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("imds forbidden condition seen");

`else

`define IMDS_ASSERT(label, clk, rst_n, prop)
`define IMDS_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- hw/rtl/imds_pkg.sv -----
// shared types, codes and step functions of the integer multiply, divide and square-root unit
package imds_pkg;

    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_MUL8   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MUL16U = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL16S = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SQRT   = 3'd4;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_DOMAIN = 1'b1;

    localparam int HALF_W = 16;

    // 32 quotient bits and 16 root bits spread evenly over the iteration stages
    localparam int ITER_STAGES  = 8;
    localparam int DIV_PER_STG  = 32 / ITER_STAGES;
    localparam int SQRT_PER_STG = HALF_W / ITER_STAGES;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [31:0]       val;      // dividend or radicand, shifted out from the top
        logic [15:0]       divisor;
        logic [16:0]       rem;      // partial remainder
        logic [15:0]       root;
        logic [31:0]       prod;
    } t_stage;

    // restoring division: one quotient bit shifts into val per step
    function automatic t_stage div_steps(input t_stage s_i);
        t_stage      s_o;
        logic [16:0] t;
        logic        q;
        s_o = s_i;
        for (int k = 0; k < DIV_PER_STG; k++) begin
            t = {s_o.rem[15:0], s_o.val[31]};
            q = (t >= {1'b0, s_o.divisor});
            s_o.rem = q ? (t - {1'b0, s_o.divisor}) : t;
            s_o.val = {s_o.val[30:0], q};
        end
        return s_o;
    endfunction

    // digit-by-digit square root, two radicand bits per step
    function automatic t_stage sqrt_steps(input t_stage s_i);
        t_stage      s_o;
        logic [18:0] r2;
        logic [18:0] trial;
        logic        q;
        s_o = s_i;
        for (int k = 0; k < SQRT_PER_STG; k++) begin
            r2    = {s_o.rem, s_o.val[31:30]};
            trial = {1'b0, s_o.root, 2'b01};
            q     = (r2 >= trial);
            r2    = q ? (r2 - trial) : r2;
            s_o.rem  = r2[16:0];
            s_o.root = {s_o.root[14:0], q};
            s_o.val  = {s_o.val[29:0], 2'b00};
        end
        return s_o;
    endfunction

    function automatic t_stage stage_step(input t_stage s_i);
        t_stage s_o;
        s_o = s_i;
        if (s_i.func == FUNC_DIV) begin
            s_o = div_steps(s_i);
        end else if (s_i.func == FUNC_SQRT) begin
            s_o = sqrt_steps(s_i);
        end
        return s_o;
    endfunction

endpackage

// ----- hw/rtl/integer_mul_div_sqrt_unit.sv -----
// top level of the integer multiply, divide and square-root unit
// Pipelined math unit: one beat in, one beat out, and a new beat can be taken every
// cycle unless back-pressure from the output fills the pipeline. A beat passes an input
// register (which also holds the 17x17 product), eight iteration stages (four divide
// steps or two square-root steps each) and an output register. Each stage moves on its
// own when the one after it is empty or moving, so a stalled output fills the bubbles
// before the input side sees tready drop. Division by zero returns zero with status 1;
// unused function codes return zero with status 0.
`include "integer_mul_div_sqrt_unit_macros.svh"

module integer_mul_div_sqrt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // operand_a[31:0], operand_b[47:32]
    input  logic [2:0]  i_s_axis_tuser,   // func[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // result[31:0]
    output logic        o_m_axis_tuser    // status[0]
);

    localparam int NSTG = imds_pkg::ITER_STAGES;

    imds_pkg::t_stage r_stg [0:NSTG];
    logic [NSTG:0]    r_vld;
    logic [NSTG:0]    ld;
    logic             ld_out;

    logic             r_out_vld;
    logic [31:0]      r_out_res;
    logic             r_out_st;
    logic [31:0]      n_out_res;
    logic             n_out_st;

    imds_pkg::t_stage n_in;
    logic [16:0]      mul_a;
    logic [16:0]      mul_b;
    logic [33:0]      mul_p;

    // a slot loads when it is empty or its contents move on
    always_comb begin
        ld_out = !r_out_vld || i_m_axis_tready;
        ld[NSTG] = !r_vld[NSTG] || ld_out;
        for (int k = NSTG - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_s_axis_tready = ld[0];

    // operand widening: zero for unsigned kinds, sign for the signed multiply
    always_comb begin
        mul_a = 17'd0;
        mul_b = 17'd0;
        case (i_s_axis_tuser)
            imds_pkg::FUNC_MUL8: begin
                mul_a = {9'd0, i_s_axis_tdata[7:0]};
                mul_b = {9'd0, i_s_axis_tdata[39:32]};
            end
            imds_pkg::FUNC_MUL16U: begin
                mul_a = {1'b0, i_s_axis_tdata[15:0]};
                mul_b = {1'b0, i_s_axis_tdata[47:32]};
            end
            imds_pkg::FUNC_MUL16S: begin
                mul_a = {i_s_axis_tdata[15], i_s_axis_tdata[15:0]};
                mul_b = {i_s_axis_tdata[47], i_s_axis_tdata[47:32]};
            end
            default: begin
                mul_a = 17'd0;
                mul_b = 17'd0;
            end
        endcase
        mul_p = 34'($signed(mul_a) * $signed(mul_b));

        n_in.func    = i_s_axis_tuser;
        n_in.val     = i_s_axis_tdata[31:0];
        n_in.divisor = i_s_axis_tdata[47:32];
        n_in.rem     = 17'd0;
        n_in.root    = 16'd0;
        n_in.prod    = mul_p[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k <= NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_stg[0] <= n_in;
        end
        for (int k = 1; k <= NSTG; k++) begin
            if (ld[k]) begin
                r_stg[k] <= imds_pkg::stage_step(r_stg[k-1]);
            end
        end
    end

    // result packing from the last iteration stage
    always_comb begin
        n_out_res = 32'd0;
        n_out_st  = imds_pkg::STATUS_OK;
        case (r_stg[NSTG].func) inside
            imds_pkg::FUNC_MUL8, imds_pkg::FUNC_MUL16U, imds_pkg::FUNC_MUL16S: begin
                n_out_res = r_stg[NSTG].prod;
            end
            imds_pkg::FUNC_DIV: begin
                if (r_stg[NSTG].divisor == 16'd0) begin
                    n_out_st = imds_pkg::STATUS_DOMAIN;
                end else begin
                    n_out_res = {r_stg[NSTG].rem[15:0], r_stg[NSTG].val[15:0]};
                end
            end
            imds_pkg::FUNC_SQRT: begin
                n_out_res = {16'd0, r_stg[NSTG].root};
            end
            default: begin
                n_out_res = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ld_out) begin
            r_out_vld <= r_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_res <= n_out_res;
            r_out_st  <= n_out_st;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_res;
    assign o_m_axis_tuser  = r_out_st;

    // a domain error always carries a zero result
    `IMDS_ASSERT(a_err_zero, i_clk, i_rst_n, (r_out_vld && r_out_st) |-> (r_out_res == 32'd0))
    // input side only stalls when the first slot is full
    `IMDS_NEVER(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready && !r_vld[0])
    // a beat leaving the last stage lands in the output register
    `IMDS_ASSERT(a_drain, i_clk, i_rst_n, (r_vld[NSTG] && ld_out) |=> r_out_vld)
    // square root never exceeds sixteen bits
    `IMDS_NEVER(a_root_w, i_clk, i_rst_n,
        r_out_vld && (r_out_res[31:16] != 16'd0) && (r_stg[NSTG].func == imds_pkg::FUNC_SQRT) &&
        $past(ld_out) && $past(r_stg[NSTG].func == imds_pkg::FUNC_SQRT))

endmodule

// ----- bench/imds_result_checker.sv -----
// checker for the integer multiply, divide and square-root unit: predicts and compares result beats
module imds_result_checker
    import imds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_tvalid,
    input  logic              i_op_tready,
    input  logic [47:0]       i_op_tdata,    // operand_a[31:0], operand_b[47:32]
    input  logic [FUNC_W-1:0] i_op_tuser,    // func[2:0]
    input  logic              i_res_tvalid,
    input  logic              i_res_tready,
    input  logic [31:0]       i_res_tdata,   // result[31:0]
    input  logic              i_res_tuser,   // status[0]
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_compared,
    output int                o_domain_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic        status;
    } t_math_reply;

    t_math_reply awaited_replies[$];
    int          mismatch_count = 0;
    int          compared_count = 0;
    int          domain_count   = 0;
    int          outstanding_q  = 0;

    assign o_mismatches    = mismatch_count;
    assign o_compared      = compared_count;
    assign o_domain_errors = domain_count;
    assign o_outstanding   = outstanding_q;

    // largest root whose square still fits under the radicand
    function automatic logic [31:0] floor_sqrt(input logic [31:0] radicand);
        logic [31:0] root;
        logic [31:0] trial;
        logic [63:0] square;
        root = '0;
        for (int i = HALF_W - 1; i >= 0; i--) begin
            trial  = root | (32'd1 << i);
            square = trial * trial;
            if (square <= {32'd0, radicand}) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_math_reply compute_reply(input logic [FUNC_W-1:0] func,
                                                  input logic [31:0] a,
                                                  input logic [15:0] b);
        t_math_reply        reply;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0]        quo;
        logic [31:0]        rem;
        reply.word   = '0;
        reply.status = STATUS_OK;
        case (func)
            FUNC_MUL8: begin
                reply.word = {24'd0, a[7:0]} * {24'd0, b[7:0]};
            end
            FUNC_MUL16U: begin
                reply.word = {16'd0, a[15:0]} * {16'd0, b};
            end
            FUNC_MUL16S: begin
                sa = $signed(a[15:0]);
                sb = $signed(b);
                reply.word = sa * sb;
            end
            FUNC_DIV: begin
                if (b == 16'd0) begin
                    reply.status = STATUS_DOMAIN;
                end else begin
                    quo = a / {16'd0, b};
                    rem = a % {16'd0, b};
                    // quotient keeps only its low half, so it wraps on overflow
                    reply.word = {rem[15:0], quo[15:0]};
                end
            end
            FUNC_SQRT: begin
                reply.word = floor_sqrt(a);
            end
            default: begin
                reply.word = '0;
            end
        endcase
        return reply;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_math_reply want;
        t_math_reply got;
        if (!i_rst_n) begin
            awaited_replies.delete();
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                got.word   = i_res_tdata;
                got.status = i_res_tuser;
                if (awaited_replies.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing pending: result=%h status=%b",
                                            got.word, got.status));
                end else begin
                    want = awaited_replies.pop_front();
                    compared_count++;
                    if (got.word !== want.word || got.status !== want.status) begin
                        flag_mismatch($sformatf(
                            "beat %0d expected result=%h status=%b, got result=%h status=%b",
                            compared_count, want.word, want.status, got.word, got.status));
                    end
                end
            end
            if (i_op_tvalid && i_op_tready) begin
                want = compute_reply(i_op_tuser, i_op_tdata[31:0], i_op_tdata[47:32]);
                if (want.status == STATUS_DOMAIN) begin
                    domain_count++;
                end
                awaited_replies.push_back(want);
            end
        end
        outstanding_q <= awaited_replies.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// testbench top for the integer multiply, divide and square-root unit: stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imds_pkg::*;

    localparam int RANDOM_OPS     = 1800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 24;
    localparam logic [FUNC_W-1:0] FUNC_LAST = '1;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              op_tvalid   = 1'b0;
    logic              op_tready;
    logic [47:0]       op_tdata    = '0;   // operand_a[31:0], operand_b[47:32]
    logic [FUNC_W-1:0] op_tuser    = '0;   // func[2:0]
    logic              res_tvalid;
    logic              res_tready  = 1'b0;
    logic [31:0]       res_tdata;          // result[31:0]
    logic              res_tuser;          // status[0]

    int mismatches;
    int outstanding;
    int compared;
    int domain_errors;
    int ops_per_func[8];
    int quiet_cycles = 0;
    bit steady_feed  = 1'b0;

    integer_mul_div_sqrt_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (op_tvalid),
        .o_s_axis_tready (op_tready),
        .i_s_axis_tdata  (op_tdata),
        .i_s_axis_tuser  (op_tuser),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tuser  (res_tuser)
    );

    imds_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_tvalid     (op_tvalid),
        .i_op_tready     (op_tready),
        .i_op_tdata      (op_tdata),
        .i_op_tuser      (op_tuser),
        .i_res_tvalid    (res_tvalid),
        .i_res_tready    (res_tready),
        .i_res_tdata     (res_tdata),
        .i_res_tuser     (res_tuser),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_compared      (compared),
        .o_domain_errors (domain_errors)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return ~(32'd1 << $urandom_range(0, 31));
            4: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return '1;
            2: return 16'd1 << $urandom_range(0, 15);
            3: return 16'h8000 | 16'($urandom_range(0, 15));
            4: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic issue_op(input logic [FUNC_W-1:0] func, input logic [31:0] a,
                            input logic [15:0] b);
        op_tvalid <= 1'b1;
        op_tdata  <= {b, a};
        op_tuser  <= func;
        do @(posedge i_clk); while (!op_tready);
        ops_per_func[func]++;
    endtask

    // drop valid for a random gap unless the feed is running flat out
    task automatic sender_gap();
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        if (gap > 0) begin
            op_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        op_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic issue_random_op();
        logic [FUNC_W-1:0] func;
        logic [31:0]       a;
        logic [15:0]       b;
        logic [31:0]       root;
        logic [31:0]       quo;
        a = pick_word();
        b = pick_half();
        if ($urandom_range(0, 99) < 92) begin
            func = FUNC_W'($urandom_range(FUNC_MUL8, FUNC_SQRT));
        end else begin
            func = FUNC_W'($urandom_range(FUNC_SQRT + 1, FUNC_LAST));
        end
        if (func == FUNC_DIV && $urandom_range(0, 1) == 0) begin
            // quotient that fits in 16 bits, remainder below the divisor
            b   = 16'($urandom_range(1, 65535));
            quo = $urandom_range(0, 65535);
            a   = b * quo + $urandom_range(0, b - 1);
        end else if (func == FUNC_SQRT && $urandom_range(0, 9) < 4) begin
            root = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: a = root * root;
                1: a = root * root - 1;
                2: a = root * root + 1;
                default: a = root * root + 2 * root;
            endcase
        end
        issue_op(func, a, b);
    endtask

    initial begin : sink_pacing
        int burst;
        int stall;
        forever begin
            burst = $urandom_range(1, 64);
            res_tready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                res_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // ends the run if neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (op_tvalid && op_tready) || (res_tvalid && res_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: operand extremes, ignored upper bits, sign corners, divide and root corners
        issue_op(FUNC_MUL8,   32'hFFFF_FFFF, 16'hFFFF);
        issue_op(FUNC_MUL8,   32'h0000_0000, 16'h00FF);
        issue_op(FUNC_MUL16U, 32'h0000_FFFF, 16'hFFFF);
        sender_gap();
        issue_op(FUNC_MUL16U, 32'hFFFF_1234, 16'h0000);
        issue_op(FUNC_MUL16S, 32'h0000_8000, 16'h8000);
        issue_op(FUNC_MUL16S, 32'h0000_FFFF, 16'h0001);
        issue_op(FUNC_MUL16S, 32'h0000_7FFF, 16'h8000);
        issue_op(FUNC_MUL16S, 32'hABCD_2345, 16'hFFFE);
        sender_gap();
        issue_op(FUNC_DIV,    32'h1234_5678, 16'h0000);
        issue_op(FUNC_DIV,    32'hFFFF_FFFF, 16'h0001);
        issue_op(FUNC_DIV,    32'hFFFF_FFFF, 16'hFFFF);
        issue_op(FUNC_DIV,    32'd100,       16'd7);
        issue_op(FUNC_DIV,    32'd0,         16'd5);
        issue_op(FUNC_DIV,    32'd5,         16'd100);
        sender_gap();
        issue_op(FUNC_SQRT,   32'd0,         16'hFFFF);
        issue_op(FUNC_SQRT,   32'd1,         16'h0000);
        issue_op(FUNC_SQRT,   32'hFFFF_FFFF, 16'h0000);
        issue_op(FUNC_SQRT,   32'hFFFE_0001, 16'h0000);
        issue_op(FUNC_SQRT,   32'hFFFE_0000, 16'h5555);
        issue_op(FUNC_SQRT,   32'd3,         16'h0000);
        issue_op(FUNC_SQRT,   32'd4,         16'h0000);
        for (int f = FUNC_SQRT + 1; f <= FUNC_LAST; f++) begin
            issue_op(FUNC_W'(f), 32'hDEAD_BEEF, 16'hFFFF);
        end
        drain_results();

        // random: alternate gapped and back-to-back blocks, full drain now and then
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 300 == 299) begin
                drain_results();
            end
            steady_feed = ((n / 150) % 2) == 1;
            sender_gap();
            issue_random_op();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ops sent: mul8 %0d, mul16u %0d, mul16s %0d, div %0d, sqrt %0d, spare codes %0d",
                 ops_per_func[FUNC_MUL8], ops_per_func[FUNC_MUL16U], ops_per_func[FUNC_MUL16S],
                 ops_per_func[FUNC_DIV], ops_per_func[FUNC_SQRT],
                 ops_per_func[5] + ops_per_func[6] + ops_per_func[7]);
        $display("result beats compared: %0d (divide by zero %0d), mismatches %0d",
                 compared, domain_errors, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
